// ===== src/wpid_pkg.sv =====
package wpid_pkg;

    localparam int COUNTS_PER_REV = 400;
    localparam int WINDOW_HALF    = 50;
    localparam int FREQ_LIMIT     = 1500;
    localparam int SETTLE_MAG     = 50;
    localparam int SETTLE_ERR     = 2;
    localparam int TIMER_CLOCK    = 1000000;
    localparam int RELOAD_MAX     = 499999;

    localparam int WIN_LO = COUNTS_PER_REV / 2 - WINDOW_HALF;
    localparam int WIN_HI = COUNTS_PER_REV / 2 + WINDOW_HALF;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 40;
    localparam int GAIN_W   = 16;
    localparam int POS_W    = 9;
    localparam int ERR_W    = 11;
    localparam int FREQ_W   = 11;
    localparam int RELOAD_W = 19;

    // count reduction: 400 = 16 * 25, drop the low four bits and take the odd
    // factor out by reciprocal multiplication (exact for a 12-bit operand)
    localparam int MOD_SHIFT = 4;
    localparam int MOD_ODD   = COUNTS_PER_REV >> MOD_SHIFT;
    localparam int MOD_FRAC  = 16;
    localparam int MOD_RECIP = ((1 << MOD_FRAC) + MOD_ODD - 1) / MOD_ODD;
    localparam int RECIP_W   = 12;
    localparam int HI_W      = IN_W - MOD_SHIFT;
    localparam int QMOD_W    = HI_W + RECIP_W - MOD_FRAC;

    // reload divider: 20-bit dividend, 11-bit divisor, one quotient bit per cycle
    localparam int DVD_W     = 20;
    localparam int DSR_W     = 11;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = 5;

    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;
    localparam logic [1:0] REG_TARGET = 2'd3;

    localparam logic [1:0] MUL_P = 2'd0;
    localparam logic [1:0] MUL_I = 2'd1;
    localparam logic [1:0] MUL_D = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       div_step;
        logic       win_load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       commit;
        logic       eval;
        logic       rel_load;
        logic       out_load;
    } wpid_cmd_t;

    typedef struct packed {
        logic in_window;
        logic need_div;
    } wpid_stat_t;

endpackage

// ===== src/wpid_div.sv =====
module wpid_div (
    input  logic                       clk,
    input  logic                       start,
    input  logic                       step,
    input  logic [wpid_pkg::DVD_W-1:0] dividend,
    input  logic [wpid_pkg::DSR_W-1:0] divisor,
    output logic [wpid_pkg::DVD_W-1:0] quotient
);
    import wpid_pkg::*;

    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] dvd_next;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] rem_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] dsr_next;
    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] trial;

    // restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DVD_W-1]};
        trial    = {1'b0, shifted} - {2'b00, dsr_reg};
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (step)
        begin
            if (!trial[DSR_W+1])
            begin
                rem_next = trial[DSR_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DSR_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = dvd_reg;

endmodule

// ===== src/wpid_ctrl.sv =====
module wpid_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  wpid_pkg::wpid_stat_t  stat,
    output wpid_pkg::wpid_cmd_t   cmd
);
    import wpid_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MOD  = 4'd1;
    localparam logic [3:0] S_WIN  = 4'd2;
    localparam logic [3:0] S_M0   = 4'd3;
    localparam logic [3:0] S_M1   = 4'd4;
    localparam logic [3:0] S_M2   = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_EVAL = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_REL  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic             last_step;

    assign last_step = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_MOD;
                end
            end
            S_MOD:
            begin
                // let the reduction quotient settle in the datapath
                state_next = S_WIN;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_REL;
                end
            end
            S_WIN:
            begin
                cmd.win_load = 1'b1;
                state_next   = stat.in_window ? S_M0 : S_OUT;
            end
            S_M0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = S_M1;
            end
            S_M1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_I;
                cmd.acc_load = 1'b1;
                state_next   = S_M2;
            end
            S_M2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                cmd.acc_add = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                cmd.commit  = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                cnt_next = '0;
                state_next = stat.need_div ? S_DIV : S_OUT;
            end
            S_REL:
            begin
                cmd.rel_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== src/wpid_dp.sv =====
module wpid_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [wpid_pkg::IN_W-1:0]  s_tdata,
    output logic [wpid_pkg::OUT_W-1:0] m_tdata,
    input  logic                       cfg_wen,
    input  logic [1:0]                 cfg_index,
    input  logic [wpid_pkg::GAIN_W-1:0] cfg_data,
    input  wpid_pkg::wpid_cmd_t        cmd,
    output wpid_pkg::wpid_stat_t       stat
);
    import wpid_pkg::*;

    logic [GAIN_W-1:0]   gain_p_reg;
    logic [GAIN_W-1:0]   gain_i_reg;
    logic [GAIN_W-1:0]   gain_d_reg;
    logic [POS_W-1:0]    target_reg;
    logic [GAIN_W-1:0]   error_sum_reg;
    logic [GAIN_W-1:0]   prev_err_reg;

    logic [IN_W-1:0]     raw_reg;
    logic [QMOD_W-1:0]   q_mod_reg;
    logic [ERR_W-1:0]    err_reg;
    logic [GAIN_W-1:0]   prod_reg;
    logic [GAIN_W-1:0]   acc_reg;
    logic [GAIN_W-1:0]   acc_next;

    logic                res_win_reg;
    logic                res_rev_reg;
    logic                res_set_reg;
    logic                res_men_reg;
    logic [FREQ_W-1:0]   res_freq_reg;
    logic [RELOAD_W-1:0] res_rel_reg;
    logic                res_rv_reg;
    logic                res_dz_reg;
    logic [OUT_W-1:0]    tdata_reg;

    logic [DVD_W-1:0]    div_dividend;
    logic [DSR_W-1:0]    div_divisor;
    logic [DVD_W-1:0]    quotient;
    logic                div_start;

    logic [HI_W-1:0]     raw_hi;
    logic [HI_W+RECIP_W-1:0] recip_prod;
    logic [HI_W-1:0]     odd_prod;
    logic [HI_W-1:0]     odd_rem;
    logic [POS_W-1:0]    pos;
    logic [ERR_W-1:0]    err;
    logic [GAIN_W-1:0]   err16;
    logic [GAIN_W-1:0]   sum_new;
    logic [GAIN_W-1:0]   diff16;
    logic [GAIN_W-1:0]   mul_a;
    logic [GAIN_W-1:0]   mul_b;
    logic [2*GAIN_W-1:0] mul_full;
    logic [GAIN_W:0]     mag;
    logic [FREQ_W-1:0]   mag_clamp;
    logic                done;
    logic [DVD_W-1:0]    q_minus;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_W'(18);
            gain_i_reg <= '0;
            gain_d_reg <= GAIN_W'(2);
            target_reg <= POS_W'(198);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_GAIN_P: gain_p_reg <= cfg_data;
                REG_GAIN_I: gain_i_reg <= cfg_data;
                REG_GAIN_D: gain_d_reg <= cfg_data;
                REG_TARGET: target_reg <= cfg_data[POS_W-1:0];
                default:    ;
            endcase
        end
    end

    // count modulo one revolution: low bits pass, the odd factor comes from
    // a registered reciprocal quotient
    assign raw_hi     = raw_reg[IN_W-1:MOD_SHIFT];
    assign recip_prod = raw_hi * RECIP_W'(MOD_RECIP);
    assign odd_prod   = {{(HI_W-QMOD_W){1'b0}}, q_mod_reg} * HI_W'(MOD_ODD);
    assign odd_rem    = raw_hi - odd_prod;
    assign pos        = {odd_rem[POS_W-MOD_SHIFT-1:0], raw_reg[MOD_SHIFT-1:0]};

    // the divider forms the timer reload once the drive magnitude is known
    assign div_start    = cmd.eval;
    assign div_dividend = DVD_W'(TIMER_CLOCK);
    assign div_divisor  = mag_clamp;

    wpid_div u_div (
        .clk       (clk),
        .start     (div_start),
        .step      (cmd.div_step),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (quotient)
    );

    assign stat.in_window = (pos > POS_W'(WIN_LO)) && (pos < POS_W'(WIN_HI));
    assign err            = {2'b00, target_reg} - {2'b00, pos};

    assign err16   = {{(GAIN_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign sum_new = error_sum_reg + err16;
    assign diff16  = err16 - prev_err_reg;

    // only the low 16 bits of each product reach the truncated output
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = err16;
            end
            MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = sum_new;
            end
            default:
            begin
                mul_a = gain_d_reg;
                mul_b = diff16;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_load)
        begin
            acc_next = prod_reg;
        end
        else if (cmd.acc_add)
        begin
            acc_next = acc_reg + prod_reg;
        end
    end

    // magnitude of the truncated output; the most negative value gives 32768
    assign mag       = acc_reg[GAIN_W-1] ? ((GAIN_W+1)'(1) << GAIN_W) - {1'b0, acc_reg}
                                         : {1'b0, acc_reg};
    assign mag_clamp = (mag > (GAIN_W+1)'(FREQ_LIMIT)) ? FREQ_W'(FREQ_LIMIT)
                                                      : mag[FREQ_W-1:0];
    assign done      = (mag_clamp <= FREQ_W'(SETTLE_MAG))
                       && ($signed(err_reg) <= $signed(ERR_W'(SETTLE_ERR)));
    assign stat.need_div = !done && (mag_clamp != '0);
    assign q_minus   = quotient - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            raw_reg <= s_tdata;
        end
        q_mod_reg <= recip_prod[HI_W+RECIP_W-1:MOD_FRAC];
        if (cmd.win_load)
        begin
            err_reg      <= err;
            res_win_reg  <= 1'b0;
            res_rev_reg  <= 1'b0;
            res_set_reg  <= 1'b0;
            res_men_reg  <= 1'b0;
            res_freq_reg <= '0;
            res_rel_reg  <= '0;
            res_rv_reg   <= 1'b0;
            res_dz_reg   <= 1'b0;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_full[GAIN_W-1:0];
        end
        acc_reg <= acc_next;
        if (cmd.eval)
        begin
            res_win_reg  <= 1'b1;
            res_rev_reg  <= acc_reg[GAIN_W-1] || (acc_reg == '0);
            res_set_reg  <= done;
            res_men_reg  <= !done;
            res_freq_reg <= mag_clamp;
            res_rv_reg   <= !done;
            res_dz_reg   <= !done && (mag_clamp == '0);
            res_rel_reg  <= (!done && (mag_clamp == '0)) ? RELOAD_W'(RELOAD_MAX) : '0;
        end
        if (cmd.rel_load)
        begin
            res_rel_reg <= q_minus[RELOAD_W:1];
        end
        if (cmd.out_load)
        begin
            tdata_reg <= {{(OUT_W-36){1'b0}}, res_dz_reg, res_rv_reg, res_rel_reg,
                          res_freq_reg, res_men_reg, res_set_reg, res_rev_reg,
                          res_win_reg};
        end
    end

    // integral and last error advance only when the step ran
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            error_sum_reg <= sum_new;
            prev_err_reg  <= err16;
        end
    end

    assign m_tdata = tdata_reg;

endmodule

// ===== src/windowed_pid_stepper_rate.sv =====
// Outside the window a result goes from the window check straight to the output; inside
// it the shared multiplier forms the P, I and D terms in turn, then the 20-step reload
// divider runs unless the step settled or the frequency is zero. One item at a time: no
// new input is taken until the last result is in the output register, and a finished
// result may wait for m_tready.
// Reset (rst_n, asynchronous, active low) restores gains, setpoint, integral, last error.
module windowed_pid_stepper_rate (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [wpid_pkg::IN_W-1:0]   s_tdata,  // [15:0] raw_count
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] in_window, [1] reverse_dir, [2] settled, [3] motor_enable,
    // [14:4] drive_freq, [33:15] reload_value, [34] reload_valid, [35] div_zero
    output logic [wpid_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_wen,
    input  logic [1:0]                  cfg_index,
    input  logic [wpid_pkg::GAIN_W-1:0] cfg_data
);
    import wpid_pkg::*;

    wpid_cmd_t  cmd;
    wpid_stat_t stat;

    wpid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wpid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // one item at a time: no second transaction straight after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[35:0] == 36'd0)
        else $error("result outside window is not all zero");

    a_settled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[3] && !m_tdata[34] && !m_tdata[35]
                                   && m_tdata[33:15] == '0)
        else $error("settled result drives the motor or reload");

    a_div_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[35] |-> m_tdata[33:15] == RELOAD_W'(RELOAD_MAX)
                                    && m_tdata[14:4] == '0)
        else $error("div_zero without saturated reload");

endmodule

// ===== tb/sv/windowed_pid_stepper_rate_tb.sv =====
module windowed_pid_stepper_rate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wpid_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 50;

    // one drive command, laid out as m_tdata from the top bit down
    typedef struct packed {
        logic [3:0]  pad;
        logic        div_zero;
        logic        reload_valid;
        logic [18:0] reload_value;
        logic [10:0] drive_freq;
        logic        motor_enable;
        logic        settled;
        logic        reverse_dir;
        logic        in_window;
    } drive_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_wen = 1'b0;
    logic [1:0]         cfg_index = REG_GAIN_P;
    logic [GAIN_W-1:0]  cfg_data = '0;

    // controller copy: gains, setpoint, integral and last error
    logic signed [15:0] ctrl_gain_p = 16'sd18;
    logic signed [15:0] ctrl_gain_i = 16'sd0;
    logic signed [15:0] ctrl_gain_d = 16'sd2;
    logic [8:0]         ctrl_target = 9'd198;
    logic signed [15:0] integ_sum = '0;
    logic signed [15:0] last_error = '0;

    logic [15:0]        count_q[$];
    drive_cmd_t         drive_cmd_q[$];

    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;
    bit  no_idle = 1'b0;
    int  send_gap = 0;
    int  ready_wait = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  n_checked = 0;
    int  n_window = 0;
    int  n_settled = 0;
    int  n_divzero = 0;
    int  n_clamped = 0;

    windowed_pid_stepper_rate uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] raw_count
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [0] in_window, [1] reverse_dir, [2] settled, [3] motor_enable,
        // [14:4] drive_freq, [33:15] reload_value, [34] reload_valid, [35] div_zero
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic drive_cmd_t control_step(input logic [15:0] raw);
        int         pos;
        int         err;
        int         outv;
        int         mag;
        bit         done;
        longint     acc;
        drive_cmd_t r;
        r = '0;
        pos = int'(raw) % COUNTS_PER_REV;
        if (pos <= WIN_LO || pos >= WIN_HI)
            return r;
        err = int'(ctrl_target) - pos;
        integ_sum = integ_sum + 16'(err);
        acc = longint'(ctrl_gain_p) * err
            + longint'(ctrl_gain_i) * longint'(integ_sum)
            + longint'(ctrl_gain_d) * longint'(err - int'(last_error));
        outv = int'($signed(acc[15:0]));
        last_error = 16'(err);
        mag = (outv < 0) ? -outv : outv;
        if (mag > FREQ_LIMIT)
            mag = FREQ_LIMIT;
        done = (mag <= SETTLE_MAG) && (err <= SETTLE_ERR);
        r.in_window = 1'b1;
        r.reverse_dir = (outv <= 0);
        r.settled = done;
        r.motor_enable = !done;
        r.drive_freq = 11'(mag);
        if (!done)
        begin
            r.reload_valid = 1'b1;
            if (mag == 0)
            begin
                r.reload_value = 19'(RELOAD_MAX);
                r.div_zero = 1'b1;
            end
            else
                r.reload_value = 19'((TIMER_CLOCK / mag - 1) / 2);
        end
        return r;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         n_checked, name, want, got);
        end
    endtask

    // track handshakes at the rising edge
    always @(posedge clk)
    begin
        in_fire <= rst_n && s_tvalid && s_tready;
        out_fire <= rst_n && m_tvalid && m_tready;
        cycles <= cycles + 1;
        if (rst_n && s_tvalid && s_tready)
            drive_cmd_q.push_back(control_step(s_tdata));
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        drive_cmd_t want;
        drive_cmd_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (drive_cmd_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: %h", m_tdata);
            end
            else
            begin
                want = drive_cmd_q.pop_front();
                check_field("in_window", want.in_window, got.in_window);
                check_field("reverse_dir", want.reverse_dir, got.reverse_dir);
                check_field("settled", want.settled, got.settled);
                check_field("motor_enable", want.motor_enable, got.motor_enable);
                check_field("drive_freq", want.drive_freq, got.drive_freq);
                check_field("reload_value", want.reload_value, got.reload_value);
                check_field("reload_valid", want.reload_valid, got.reload_valid);
                check_field("div_zero", want.div_zero, got.div_zero);
                check_field("padding", want.pad, got.pad);
                n_checked++;
                n_window += want.in_window;
                n_settled += want.settled;
                n_divzero += want.div_zero;
                n_clamped += (want.drive_freq == FREQ_LIMIT);
            end
        end
    end

    // input driver: hold data until the transaction, then wait the drawn gap
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (count_q.size() != 0)
            begin
                s_tdata <= count_q.pop_front();
                s_tvalid <= 1'b1;
                send_gap <= draw_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side: stall a drawn number of cycles after each transaction
    always @(negedge clk)
    begin
        int w;
        if (rst_n)
        begin
            if (out_fire)
            begin
                w = draw_gap();
                if (w == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    ready_wait <= w - 1;
                end
            end
            else if (!m_tready)
            begin
                if (ready_wait == 0)
                    m_tready <= 1'b1;
                else
                    ready_wait <= ready_wait - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, drive_cmd_q.size());
            $display("windowed_pid_stepper_rate_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_GAIN_P: ctrl_gain_p = value;
            REG_GAIN_I: ctrl_gain_i = value;
            REG_GAIN_D: ctrl_gain_d = value;
            REG_TARGET: ctrl_target = value[8:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] gp, input logic [15:0] gi,
                            input logic [15:0] gd, input logic [15:0] tgt);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_TARGET, tgt);
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic wait_idle();
        while (count_q.size() != 0 || drive_cmd_q.size() != 0 || s_tvalid)
            @(negedge clk);
    endtask

    function automatic logic [15:0] draw_gain(input int kind);
        int pick;
        case (kind)
            0: return 16'($urandom_range(0, 16) - 8);
            1: return 16'($urandom);
            default:
            begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] in_window_count(input int pos);
        return 16'(pos + COUNTS_PER_REV * $urandom_range(0, 163));
    endfunction

    initial
    begin
        int          kind;
        int          pos;
        int          tgt;
        int          step;
        bit          walk;
        logic [15:0] tgt_data;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes, window edges, settling, zero frequency
        count_q = '{16'd0, 16'd65535, 16'd150, 16'd151, 16'd249, 16'd250,
                    16'd65400, 16'd198, 16'd198, 16'd168, 16'd195};
        wait_idle();

        // most negative controller output from both signs of error
        set_regs(16'h8000, 16'h0000, 16'h0000, 16'd198);
        count_q = '{16'd197, 16'd199, 16'd200};
        wait_idle();

        set_regs(16'h7FFF, 16'h8000, 16'h8000, 16'd511);
        count_q = '{16'd151, 16'd249, 16'd200};
        wait_idle();

        set_regs(16'd1, 16'd1, 16'd1, 16'd0);
        count_q = '{16'd249, 16'd151};
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            no_idle = (ph % 3 == 2);
            kind = (ph < 5) ? 0 : $urandom_range(0, 2);
            case ($urandom_range(0, 5))
                0: tgt_data = 16'($urandom);
                1: tgt_data = 16'($urandom_range(0, 511));
                2: tgt_data = (ph % 2) ? 16'd511 : 16'd0;
                default: tgt_data = 16'($urandom_range(WIN_LO + 1, WIN_HI - 1));
            endcase
            set_regs(draw_gain(kind), draw_gain(kind), draw_gain(kind), tgt_data);
            tgt = int'(ctrl_target);
            walk = (ph % 2 == 0);
            pos = $urandom_range(WIN_LO + 1, WIN_HI - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 9) < 2)
                    count_q.push_back(16'($urandom));
                else if (walk)
                begin
                    // close in on the setpoint, staying inside the window
                    step = $urandom_range(0, 3);
                    if (pos < tgt)
                        pos = pos + step;
                    else if (pos > tgt)
                        pos = pos - step;
                    if (pos <= WIN_LO)
                        pos = WIN_LO + 1;
                    if (pos >= WIN_HI)
                        pos = WIN_HI - 1;
                    count_q.push_back(in_window_count(pos));
                end
                else
                    count_q.push_back(in_window_count($urandom_range(WIN_LO + 1,
                                                                     WIN_HI - 1)));
            end
            wait_idle();
        end

        no_idle = 1'b0;
        wait_idle();
        repeat (60) @(posedge clk);

        $display("%0d control ticks checked: %0d in window, %0d settled,", n_checked,
                 n_window, n_settled);
        $display("%0d zero-frequency reloads, %0d clamped drives", n_divzero, n_clamped);
        if (mismatches == 0 && drive_cmd_q.size() == 0)
            $display("windowed_pid_stepper_rate_tb: clean");
        else
            $display("windowed_pid_stepper_rate_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/wpid_pkg.sv
src/wpid_div.sv
src/wpid_ctrl.sv
src/wpid_dp.sv
src/windowed_pid_stepper_rate.sv
tb/sv/windowed_pid_stepper_rate_tb.sv
